### hdl/ndt3_pkg.sv
// Shared types and constants for the NDEF Type 3 record builder.
package ndt3_pkg;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] message_length;
      logic [7:0]  data_byte;
      logic        first_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [5:0] block_number;
      logic [3:0] byte_in_block;
      logic       status;
      logic       last_of_message;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_ATTR,
      PH_HDR,
      PH_DATA,
      PH_PAD
   } phase_type;

   localparam logic [2:0] KIND_TEXT = 3'd0;
   localparam logic [2:0] KIND_URI  = 3'd1;
   localparam logic [2:0] KIND_WKR  = 3'd2;
   localparam logic [2:0] KIND_MIME = 3'd3;
   localparam logic [2:0] KIND_RAW  = 3'd4;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ACCESS_FLAG = 2'd0;

   localparam logic       STATUS_OK     = 1'b0;
   localparam logic       STATUS_REJECT = 1'b1;

   // attribute block
   localparam logic [7:0]  ATTR_VERSION   = 8'h10;
   localparam logic [7:0]  ATTR_NBR       = 8'h02;
   localparam logic [7:0]  ATTR_NBW       = 8'h01;
   localparam logic [7:0]  ATTR_NMAXB_LO  = 8'h3C;
   localparam logic [15:0] ATTR_FIXED_SUM = 16'h004F;
   localparam logic [3:0]  ATTR_POS_NBR   = 4'd1;
   localparam logic [3:0]  ATTR_POS_NBW   = 4'd2;
   localparam logic [3:0]  ATTR_POS_NMAXB = 4'd4;
   localparam logic [3:0]  ATTR_POS_FLAG  = 4'd10;
   localparam logic [3:0]  ATTR_POS_LEN_M = 4'd12;
   localparam logic [3:0]  ATTR_POS_LEN_L = 4'd13;
   localparam logic [3:0]  ATTR_POS_SUM_H = 4'd14;
   localparam logic [3:0]  ATTR_POS_SUM_L = 4'd15;

   // short record header bytes
   localparam logic [7:0] HDR_WELL_KNOWN = 8'hD1;
   localparam logic [7:0] HDR_MIME       = 8'hD2;
   localparam logic [7:0] HDR_TYPE_LEN1  = 8'h01;
   localparam logic [7:0] RTD_TEXT       = 8'h54;
   localparam logic [7:0] RTD_URI        = 8'h55;
   localparam logic [7:0] TEXT_STATUS    = 8'h02;
   localparam logic [7:0] LANG_E         = 8'h65;
   localparam logic [7:0] LANG_N         = 8'h6E;
   localparam logic [7:0] URI_NO_PREFIX  = 8'h00;
   localparam logic [7:0] PAD_BYTE       = 8'h00;

   localparam logic [13:0] MAX_SR_PAYLOAD = 14'd255;

endpackage

### hdl/ndt3_csr.sv
// Configuration register port holding the attribute access flag.
module ndt3_csr
   import ndt3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [7:0]            access_flag
);

   logic [7:0] access_flag_ff;
   logic [7:0] access_flag_in;

   always_comb begin
      access_flag_in = access_flag_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_ACCESS_FLAG) begin
         access_flag_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         access_flag_ff <= '0;
      end else begin
         access_flag_ff <= access_flag_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr == ADDR_ACCESS_FLAG) ? {24'd0, access_flag_ff} : 32'd0;
   assign access_flag = access_flag_ff;

endmodule

### hdl/ndt3_bytegen.sv
// Attribute block and record header byte tables for the held message.
module ndt3_bytegen
   import ndt3_pkg::*;
(
   input  logic [2:0]  held_kind,
   input  logic [11:0] held_length,
   input  logic [7:0]  held_type_length,
   input  logic [7:0]  access_flag,
   input  logic [3:0]  idx,
   output logic [7:0]  attr_byte,
   output logic [7:0]  hdr_byte,
   output logic [2:0]  hdr_count
);

   logic [12:0] len13;
   logic [12:0] rec_len;
   logic [15:0] sum;
   logic [7:0]  len_plus3;
   logic [7:0]  len_plus1;
   logic [7:0]  wk_payload_len;

   assign len13 = {1'b0, held_length};

   always_comb begin
      unique case (held_kind)
         KIND_TEXT: rec_len = len13 + 13'd7;
         KIND_URI:  rec_len = len13 + 13'd5;
         KIND_RAW:  rec_len = len13 - 13'd2;
         default:   rec_len = len13 + 13'd2;
      endcase
   end

   // record length stays below 2^13, so its top byte is zero
   assign sum = ATTR_FIXED_SUM + {8'd0, access_flag} + {11'd0, rec_len[12:8]}
                + {8'd0, rec_len[7:0]};

   always_comb begin
      unique case (idx)
         4'd0:           attr_byte = ATTR_VERSION;
         ATTR_POS_NBR:   attr_byte = ATTR_NBR;
         ATTR_POS_NBW:   attr_byte = ATTR_NBW;
         ATTR_POS_NMAXB: attr_byte = ATTR_NMAXB_LO;
         ATTR_POS_FLAG:  attr_byte = access_flag;
         ATTR_POS_LEN_M: attr_byte = {3'd0, rec_len[12:8]};
         ATTR_POS_LEN_L: attr_byte = rec_len[7:0];
         ATTR_POS_SUM_H: attr_byte = sum[15:8];
         ATTR_POS_SUM_L: attr_byte = sum[7:0];
         default:        attr_byte = 8'h00;
      endcase
   end

   assign len_plus3      = held_length[7:0] + 8'd3;
   assign len_plus1      = held_length[7:0] + 8'd1;
   assign wk_payload_len = held_length[7:0] - 8'd1 - held_type_length;

   always_comb begin
      hdr_byte  = 8'h00;
      hdr_count = 3'd0;
      unique case (held_kind)
         KIND_TEXT: begin
            hdr_count = 3'd7;
            unique case (idx)
               4'd0:    hdr_byte = HDR_WELL_KNOWN;
               4'd1:    hdr_byte = HDR_TYPE_LEN1;
               4'd2:    hdr_byte = len_plus3;
               4'd3:    hdr_byte = RTD_TEXT;
               4'd4:    hdr_byte = TEXT_STATUS;
               4'd5:    hdr_byte = LANG_E;
               default: hdr_byte = LANG_N;
            endcase
         end
         KIND_URI: begin
            hdr_count = 3'd5;
            unique case (idx)
               4'd0:    hdr_byte = HDR_WELL_KNOWN;
               4'd1:    hdr_byte = HDR_TYPE_LEN1;
               4'd2:    hdr_byte = len_plus1;
               4'd3:    hdr_byte = RTD_URI;
               default: hdr_byte = URI_NO_PREFIX;
            endcase
         end
         KIND_WKR, KIND_MIME: begin
            hdr_count = 3'd3;
            unique case (idx)
               4'd0:    hdr_byte = (held_kind == KIND_WKR) ? HDR_WELL_KNOWN : HDR_MIME;
               4'd1:    hdr_byte = held_type_length;
               default: hdr_byte = wk_payload_len;
            endcase
         end
         default: begin
            hdr_byte  = 8'h00;
            hdr_count = 3'd0;
         end
      endcase
   end

endmodule

### hdl/ndt3_seq.sv
// Item register, message state and result sequencer.
module ndt3_seq
   import ndt3_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 512
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic [7:0] access_flag,
   input  logic       adv,
   output logic       emit,
   output rsp_type    emit_data
);

   localparam int unsigned RP_W = $clog2(BUFFER_BYTES) + 1;
   localparam logic [13:0] BUF_LIM = 14'(BUFFER_BYTES);

   phase_type      phase_ff, phase_in;
   req_type        item_ff, item_in;
   logic [3:0]     idx_ff, idx_in;
   logic [11:0]    bytes_taken_ff, bytes_taken_in;
   logic [2:0]     held_kind_ff, held_kind_in;
   logic [11:0]    held_length_ff, held_length_in;
   logic [7:0]     held_type_length_ff, held_type_length_in;
   logic [RP_W-1:0] record_position_ff, record_position_in;
   logic           rejected_ff, rejected_in;

   logic [7:0]     attr_byte;
   logic [7:0]     hdr_byte;
   logic [2:0]     hdr_count;
   logic           start_ok;
   logic [13:0]    len14;
   logic [13:0]    t14;
   logic           done;
   logic           active;
   logic           ending;
   logic           emit_rec;
   logic [RP_W-1:0] rp_next;
   logic [11:0]    bytes_next;
   rsp_type        rec_res;

   ndt3_bytegen u_bytegen (
      .held_kind        (held_kind_ff),
      .held_length      (held_length_ff),
      .held_type_length (held_type_length_ff),
      .access_flag      (access_flag),
      .idx              (idx_ff),
      .attr_byte        (attr_byte),
      .hdr_byte         (hdr_byte),
      .hdr_count        (hdr_count)
   );

   assign len14 = {2'd0, item_ff.message_length};
   assign t14   = {6'd0, item_ff.data_byte};

   always_comb begin
      if (len14 == 14'd0 || len14 > BUF_LIM) begin
         start_ok = 1'b0;
      end else begin
         unique case (item_ff.kind)
            KIND_TEXT:
               start_ok = !(len14 + 14'd3 > MAX_SR_PAYLOAD || len14 + 14'd3 > BUF_LIM - 14'd4);
            KIND_URI:
               start_ok = !(len14 + 14'd1 > MAX_SR_PAYLOAD || len14 + 14'd1 > BUF_LIM - 14'd4);
            KIND_WKR, KIND_MIME:
               start_ok = !((len14 < ((item_ff.kind == KIND_WKR) ? 14'd2 : 14'd3))
                            || t14 == 14'd0 || t14 + 14'd1 > len14
                            || len14 - 14'd1 - t14 > MAX_SR_PAYLOAD
                            || len14 + 14'd2 > BUF_LIM);
            KIND_RAW:
               start_ok = (len14 >= 14'd3);
            default:
               start_ok = 1'b0;
         endcase
      end
   end

   assign rp_next    = record_position_ff + {{(RP_W-1){1'b0}}, 1'b1};
   assign bytes_next = bytes_taken_ff + 12'd1;
   assign active     = !rejected_ff && (bytes_taken_ff < held_length_ff);
   assign ending     = active && (bytes_next == held_length_ff);

   always_comb begin
      if (held_kind_ff == KIND_RAW) begin
         emit_rec = (bytes_taken_ff >= 12'd2);
      end else if (held_kind_ff == KIND_WKR || held_kind_ff == KIND_MIME) begin
         emit_rec = (bytes_taken_ff >= 12'd1);
      end else begin
         emit_rec = 1'b1;
      end
   end

   always_comb begin
      rec_res.out_byte        = PAD_BYTE;
      rec_res.block_number    = 6'(record_position_ff >> 4) + 6'd1;
      rec_res.byte_in_block   = record_position_ff[3:0];
      rec_res.status          = STATUS_OK;
      rec_res.last_of_message = 1'b0;
   end

   always_comb begin
      phase_in            = phase_ff;
      item_in             = item_ff;
      idx_in              = idx_ff;
      bytes_taken_in      = bytes_taken_ff;
      held_kind_in        = held_kind_ff;
      held_length_in      = held_length_ff;
      held_type_length_in = held_type_length_ff;
      record_position_in  = record_position_ff;
      rejected_in         = rejected_ff;
      emit                = 1'b0;
      emit_data           = rec_res;
      done                = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
         end
         PH_START: begin
            if (adv) begin
               held_kind_in        = item_ff.kind;
               held_length_in      = item_ff.message_length;
               held_type_length_in = item_ff.data_byte;
               bytes_taken_in      = '0;
               record_position_in  = '0;
               emit                = 1'b1;
               emit_data.block_number  = 6'd0;
               emit_data.byte_in_block = 4'd0;
               if (!start_ok) begin
                  rejected_in               = 1'b1;
                  emit_data.out_byte        = 8'h00;
                  emit_data.status          = STATUS_REJECT;
                  emit_data.last_of_message = 1'b1;
                  done                      = 1'b1;
               end else begin
                  rejected_in        = 1'b0;
                  emit_data.out_byte = ATTR_VERSION;
                  idx_in             = 4'd1;
                  phase_in           = PH_ATTR;
               end
            end
         end
         PH_ATTR: begin
            if (adv) begin
               emit                    = 1'b1;
               emit_data.out_byte      = attr_byte;
               emit_data.block_number  = 6'd0;
               emit_data.byte_in_block = idx_ff;
               idx_in                  = idx_ff + 4'd1;
               if (idx_ff == ATTR_POS_SUM_L) begin
                  idx_in   = 4'd0;
                  phase_in = (hdr_count != 3'd0) ? PH_HDR : PH_DATA;
               end
            end
         end
         PH_HDR: begin
            if (adv) begin
               emit               = 1'b1;
               emit_data.out_byte = hdr_byte;
               record_position_in = rp_next;
               idx_in             = idx_ff + 4'd1;
               if (idx_ff == 4'(hdr_count) - 4'd1) begin
                  idx_in   = 4'd0;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (adv) begin
               done = 1'b1;
               if (active) begin
                  bytes_taken_in = bytes_next;
                  if (emit_rec) begin
                     emit                      = 1'b1;
                     emit_data.out_byte        = item_ff.data_byte;
                     record_position_in        = rp_next;
                     emit_data.last_of_message = ending && (rp_next[3:0] == 4'd0);
                     if (ending && rp_next[3:0] != 4'd0) begin
                        done     = 1'b0;
                        phase_in = PH_PAD;
                     end
                  end
               end
            end
         end
         PH_PAD: begin
            if (adv) begin
               emit               = 1'b1;
               emit_data.out_byte = PAD_BYTE;
               record_position_in = rp_next;
               if (rp_next[3:0] == 4'd0) begin
                  emit_data.last_of_message = 1'b1;
                  done                      = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      req_ready = (phase_ff == PH_IDLE) || done;

      if (req_valid && req_ready) begin
         item_in  = req_data;
         idx_in   = 4'd0;
         phase_in = req_data.first_of_message ? PH_START : PH_DATA;
      end else if (done) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         idx_ff              <= '0;
         bytes_taken_ff      <= '0;
         held_kind_ff        <= '0;
         held_length_ff      <= '0;
         held_type_length_ff <= '0;
         record_position_ff  <= '0;
         rejected_ff         <= 1'b0;
      end else begin
         phase_ff            <= phase_in;
         idx_ff              <= idx_in;
         bytes_taken_ff      <= bytes_taken_in;
         held_kind_ff        <= held_kind_in;
         held_length_ff      <= held_length_in;
         held_type_length_ff <= held_type_length_in;
         record_position_ff  <= record_position_in;
         rejected_ff         <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

### hdl/ndef_type3_record_builder_core.sv
// Top level of the NDEF Type 3 record builder: CSR, sequencer, result register.
// An accepted item is held in the item register; results pass the result register.
// Throughput: one result per cycle unless rsp_ready stalls; a data item gives at most
// one result, a message start gives the attribute block, record header and first byte,
// a message end pads up to 15 bytes, a reject is one result; set by the sequencer.
// Reset: synchronous; clears the access flag, message state and the result valid flag.
module ndef_type3_record_builder_core
   import ndt3_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 512
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic       access_flag;
   logic [7:0] access_flag_byte;
   logic       adv;
   logic       emit;
   rsp_type    emit_data;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   ndt3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .access_flag (access_flag_byte)
   );

   assign access_flag = |access_flag_byte;

   ndt3_seq #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .access_flag (access_flag_byte),
      .adv         (adv),
      .emit        (emit),
      .emit_data   (emit_data)
   );

   assign adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in = emit_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a reject is a single closing item at block 0, position 0
   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_REJECT |->
         rsp_data.last_of_message && rsp_data.block_number == 6'd0
         && rsp_data.byte_in_block == 4'd0 && rsp_data.out_byte == 8'h00)
      else $error("reject item malformed");

   // an accepted message always closes on a whole block
   a_last_fills_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.last_of_message |->
         rsp_data.byte_in_block == 4'hF && rsp_data.block_number != 6'd0)
      else $error("message ends inside a block");

   // a zero access flag reaches the flag position as a zero byte
   a_flag_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.block_number == 6'd0
      && rsp_data.byte_in_block == ATTR_POS_FLAG && !access_flag |->
         rsp_data.out_byte == 8'h00)
      else $error("access flag byte corrupted");

endmodule

### tb/testbench.sv
// Self-checking testbench for the NDEF Type 3 record builder: directed and random messages.
`timescale 1ns / 100ps

module testbench;
   import ndt3_pkg::*;

   localparam int          BUF_BYTES    = 512;
   localparam logic [2:0]  KIND_LAST    = 3'd7;
   localparam int unsigned RANDOM_ITEMS = 160;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // builder state as seen by the predictor
   logic [7:0]  flag_reg;
   logic [11:0] taken_cnt;
   logic [2:0]  msg_kind;
   logic [11:0] msg_len;
   int unsigned rec_pos;
   bit          msg_rejected;

   rsp_type     tag_bytes_due[$];
   rsp_type     pend_byte;
   bit          pend_valid = 1'b0;
   int          errors     = 0;
   int          gap_odds   = 0;
   int          stall_odds = 0;

   ndef_type3_record_builder_core #(.BUFFER_BYTES(BUF_BYTES)) u_top (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_type msg_byte(logic [2:0] k, int unsigned len, int unsigned d, bit first);
      req_type it;
      it.kind             = k;
      it.message_length   = 12'(len);
      it.data_byte        = 8'(d);
      it.first_of_message = first;
      return it;
   endfunction

   // the last byte of an item is held back so its last flag can still be set
   function automatic void emit(logic [7:0] b, int unsigned blk, int unsigned pos, logic st);
      if (pend_valid) tag_bytes_due.push_back(pend_byte);
      pend_byte.out_byte        = b;
      pend_byte.block_number    = 6'(blk);
      pend_byte.byte_in_block   = 4'(pos);
      pend_byte.status          = st;
      pend_byte.last_of_message = 1'b0;
      pend_valid                = 1'b1;
   endfunction

   function automatic void emit_record(logic [7:0] b);
      emit(b, 1 + (rec_pos >> 4), rec_pos & 15, STATUS_OK);
      rec_pos++;
   endfunction

   function automatic void close_item(bit last);
      if (pend_valid) begin
         if (last) pend_byte.last_of_message = 1'b1;
         tag_bytes_due.push_back(pend_byte);
         pend_valid = 1'b0;
      end
   endfunction

   function automatic bit start_legal(logic [2:0] k, int unsigned len, int unsigned t);
      if (len == 0 || len > BUF_BYTES) return 1'b0;
      case (k)
         KIND_TEXT: return len + 3 <= 255 && len + 3 <= BUF_BYTES - 4;
         KIND_URI:  return len + 1 <= 255 && len + 1 <= BUF_BYTES - 4;
         KIND_WKR, KIND_MIME:
            return len >= (k == KIND_WKR ? 2 : 3) && t != 0 && 1 + t <= len
                   && len - 1 - t <= 255 && len + 2 <= BUF_BYTES;
         KIND_RAW:  return len >= 3;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic void build_tag_bytes(req_type it);
      int unsigned len;
      int unsigned rl;
      int unsigned sum;
      int unsigned i;
      logic [7:0]  attr [16];
      bit          copy;
      len = {20'd0, it.message_length};
      if (it.first_of_message) begin
         msg_kind     = it.kind;
         msg_len      = it.message_length;
         taken_cnt    = '0;
         rec_pos      = 0;
         msg_rejected = 1'b0;
         if (!start_legal(it.kind, len, {24'd0, it.data_byte})) begin
            msg_rejected = 1'b1;
            emit(8'h00, 0, 0, STATUS_REJECT);
            close_item(1'b1);
            return;
         end
         case (it.kind)
            KIND_TEXT: rl = len + 7;
            KIND_URI:  rl = len + 5;
            KIND_RAW:  rl = len - 2;
            default:   rl = len + 2;
         endcase
         for (i = 0; i < 16; i++) attr[i] = 8'h00;
         attr[0]  = ATTR_VERSION;
         attr[1]  = ATTR_NBR;
         attr[2]  = ATTR_NBW;
         attr[4]  = ATTR_NMAXB_LO;
         attr[10] = flag_reg;
         attr[11] = rl[23:16];
         attr[12] = rl[15:8];
         attr[13] = rl[7:0];
         sum = 0;
         for (i = 0; i < 14; i++) sum = (sum + attr[i]) & 32'hFFFF;
         attr[14] = sum[15:8];
         attr[15] = sum[7:0];
         for (i = 0; i < 16; i++) emit(attr[i], 0, i, STATUS_OK);
         case (it.kind)
            KIND_TEXT: begin
               emit_record(HDR_WELL_KNOWN);
               emit_record(HDR_TYPE_LEN1);
               emit_record(8'(len + 3));
               emit_record(RTD_TEXT);
               emit_record(TEXT_STATUS);
               emit_record(LANG_E);
               emit_record(LANG_N);
            end
            KIND_URI: begin
               emit_record(HDR_WELL_KNOWN);
               emit_record(HDR_TYPE_LEN1);
               emit_record(8'(len + 1));
               emit_record(RTD_URI);
               emit_record(URI_NO_PREFIX);
            end
            KIND_WKR, KIND_MIME: begin
               emit_record(it.kind == KIND_WKR ? HDR_WELL_KNOWN : HDR_MIME);
               emit_record(it.data_byte);
               emit_record(8'(len - 1 - it.data_byte));
            end
            default: ;
         endcase
      end else if (msg_rejected || taken_cnt >= msg_len) begin
         return;
      end
      // type byte of well-known raw and MIME, and the two lead bytes of raw NDEF, are dropped
      case (msg_kind)
         KIND_RAW:            copy = taken_cnt >= 2;
         KIND_WKR, KIND_MIME: copy = taken_cnt >= 1;
         default:             copy = 1'b1;
      endcase
      if (copy) emit_record(it.data_byte);
      taken_cnt = taken_cnt + 1'b1;
      if (taken_cnt == msg_len) begin
         while (rec_pos % 16 != 0) emit_record(PAD_BYTE);
         close_item(1'b1);
      end else begin
         close_item(1'b0);
      end
   endfunction

   always @(posedge clock) begin : check_tag_byte
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tag_bytes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: byte %02h block %0d pos %0d status %0b last %0b",
                        rsp_data.out_byte, rsp_data.block_number, rsp_data.byte_in_block,
                        rsp_data.status, rsp_data.last_of_message);
         end else begin
            want = tag_bytes_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte
                || rsp_data.block_number !== want.block_number
                || rsp_data.byte_in_block !== want.byte_in_block
                || rsp_data.status !== want.status
                || rsp_data.last_of_message !== want.last_of_message) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %02h/%0d/%0d/%0b/%0b got %02h/%0d/%0d/%0b/%0b",
                           want.out_byte, want.block_number, want.byte_in_block,
                           want.status, want.last_of_message,
                           rsp_data.out_byte, rsp_data.block_number, rsp_data.byte_in_block,
                           rsp_data.status, rsp_data.last_of_message);
            end
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input req_type it);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      build_tag_bytes(it);
      @(negedge clock);
   endtask

   task automatic send_message(logic [2:0] k, int unsigned len, int unsigned t,
                               int unsigned count, bit mess);
      int unsigned i;
      send_item(msg_byte(k, len, t, 1'b1));
      for (i = 1; i < count; i++)
         send_item(mess ? msg_byte(3'($urandom_range(0, 7)), $urandom_range(0, 4095),
                                   $urandom, 1'b0)
                        : msg_byte(k, len, $urandom, 1'b0));
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_ACCESS_FLAG;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_access_flag(input logic [7:0] flag);
      logic [31:0] rd;
      csr_access(1'b1, {24'h0, flag}, rd);
      flag_reg = flag;
      csr_access(1'b0, 32'h0, rd);
      if (rd !== {24'h0, flag}) begin
         errors++;
         if (errors <= 10) $display("access flag readback: expected %08h got %08h", flag, rd);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tag_bytes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_message(inout int unsigned sent);
      int unsigned pick;
      int unsigned k;
      int unsigned len;
      int unsigned t;
      int unsigned count;
      int unsigned top;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // arbitrary start fields, mostly refused
         len   = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
         count = $urandom_range(1, 3);
         send_message(3'($urandom_range(0, 7)), len, $urandom, count,
                      1'($urandom_range(0, 1)));
         sent += count;
         return;
      end
      top = $urandom_range(0, 19) == 0 ? 60 : 20;
      k   = $urandom_range(KIND_TEXT, KIND_RAW);
      case (k)
         KIND_WKR:            len = $urandom_range(2, top);
         KIND_MIME, KIND_RAW: len = $urandom_range(3, top);
         default:             len = $urandom_range(1, top);
      endcase
      t = (k == KIND_WKR || k == KIND_MIME) ? $urandom_range(1, len - 1) : $urandom;
      count = len;
      if (pick < 22 && len > 1) count = $urandom_range(1, len - 1);
      send_message(3'(k), len, t, count, 1'($urandom_range(0, 1)));
      sent += count;
      if (pick >= 22 && pick < 32)
         repeat ($urandom_range(1, 3)) send_item(msg_byte(3'($urandom), $urandom, $urandom, 1'b0));
   endtask

   task automatic test_config_after_reset();
      logic [31:0] rd;
      csr_access(1'b0, 32'h0, rd);
      if (rd !== 32'h0) begin
         errors++;
         if (errors <= 10) $display("access flag after reset: expected %08h got %08h", 0, rd);
      end
      set_access_flag(8'h00);
   endtask

   task automatic test_rejects();
      int k;
      gap_odds   = 4;
      stall_odds = 4;
      send_message(KIND_TEXT, 0, 8'h41, 1, 1'b0);
      send_message(KIND_RAW, 4095, 8'hFF, 1, 1'b0);
      send_message(KIND_RAW, BUF_BYTES + 1, 8'h00, 1, 1'b0);
      for (k = KIND_RAW + 1; k <= KIND_LAST; k++) send_message(3'(k), 10, 8'h20, 1, 1'b0);
      send_message(KIND_TEXT, 253, 8'h61, 1, 1'b0);
      send_message(KIND_URI, 255, 8'h68, 1, 1'b0);
      send_message(KIND_WKR, 5, 0, 1, 1'b0);
      send_message(KIND_WKR, 4, 4, 1, 1'b0);
      send_message(KIND_WKR, 300, 1, 1, 1'b0);
      send_message(KIND_WKR, BUF_BYTES - 1, 255, 1, 1'b0);
      send_message(KIND_MIME, 2, 1, 2, 1'b0);
      send_message(KIND_RAW, 2, 8'h5A, 2, 1'b0);
   endtask

   task automatic test_shortest_messages();
      wait_idle();
      set_access_flag(8'hFF);
      send_message(KIND_TEXT, 1, 8'hFF, 1, 1'b0);
      send_message(KIND_URI, 1, 8'h00, 1, 1'b0);
      send_message(KIND_WKR, 2, 1, 2, 1'b0);
      send_message(KIND_MIME, 3, 1, 3, 1'b0);
      send_message(KIND_RAW, 3, 8'hC3, 3, 1'b0);
   endtask

   task automatic test_restart_mid_message();
      send_message(KIND_TEXT, 6, 8'h48, 3, 1'b1);
      send_message(KIND_URI, 2, 8'h77, 2, 1'b1);
   endtask

   task automatic test_longest_text();
      wait_idle();
      set_access_flag(8'($urandom));
      gap_odds   = 10;
      stall_odds = 10;
      send_message(KIND_TEXT, 252, $urandom, 252, 1'b1);
   endtask

   task automatic test_random_traffic();
      int          phase;
      int unsigned sent;
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         set_access_flag(8'($urandom));
         case (phase)
            0:       begin gap_odds = 3; stall_odds = 3; end
            1:       begin gap_odds = 0; stall_odds = 6; end
            2:       begin gap_odds = 8; stall_odds = 0; end
            default: begin gap_odds = 0; stall_odds = 0; end
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / 4) random_message(sent);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      flag_reg    = '0;
      taken_cnt   = '0;
      msg_kind    = '0;
      msg_len     = '0;
      rec_pos     = 0;
      msg_rejected = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_config_after_reset();
      test_rejects();
      test_shortest_messages();
      test_restart_mid_message();
      test_longest_text();
      test_random_traffic();
      wait_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
hdl/ndt3_pkg.sv
hdl/ndt3_csr.sv
hdl/ndt3_bytegen.sv
hdl/ndt3_seq.sv
hdl/ndef_type3_record_builder_core.sv
tb/testbench.sv
